/* rtl/core/wgbd_pkg.sv */
// shared types, register indexes and widths for the wear gated burst detector
package wgbd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_HIT_THRESHOLD     = 3'd0;
	localparam logic [2:0] REG_WORN_UPPER_BOUND  = 3'd1;
	localparam logic [2:0] REG_BURST_LENGTH      = 3'd2;
	localparam logic [2:0] REG_REFRACTORY_LENGTH = 3'd3;
	localparam logic [2:0] REG_HITS_NEEDED       = 3'd4;
	localparam logic [2:0] REG_ARM_CHUNKS        = 3'd5;
	localparam logic [2:0] REG_DISARM_CHUNKS     = 3'd6;

	// detector phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_ACTIVE = 2'd1;
	localparam logic [1:0] PH_REFR   = 2'd2;

	localparam int unsigned QueueDepth = 2;

	// configuration register set
	typedef struct packed {
		logic [31:0] hit_threshold;
		logic [31:0] worn_upper_bound;
		logic [7:0]  burst_length;
		logic [7:0]  refractory_length;
		logic [3:0]  hits_needed;
		logic [9:0]  arm_chunks;
		logic [9:0]  disarm_chunks;
	} cfg_t;

	// classification of one chunk
	typedef struct packed {
		logic worn;
		logic hit;
	} cls_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one result item
	typedef struct packed {
		logic [1:0] det_state;
		logic       disarm_pulse;
		logic       arm_pulse;
		logic       armed;
		logic       motor_drive;
	} res_t;

endpackage

/* rtl/core/wgbd_front.sv */
// front end: accepts chunk energies and classifies them as worn and hit
module wgbd_front (
	input  wgbd_pkg::cfg_t    cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       energy,
	input  wgbd_pkg::q_stat_t q_stat,
	output logic              push,
	output wgbd_pkg::cls_t    push_cls
);
	import wgbd_pkg::*;

	// accept while the queue has room
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	// worn means inside the open range above zero and below the upper bound
	always_comb begin
		push_cls.worn = (energy != 32'd0) && (energy < cfg.worn_upper_bound);
		push_cls.hit  = energy > cfg.hit_threshold;
	end

endmodule

/* rtl/core/wgbd_queue.sv */
// two entry queue of classified items between front and back ends
module wgbd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wgbd_pkg::cls_t     push_cls,
	input  logic               pop,
	output wgbd_pkg::cls_t     pop_cls,
	output wgbd_pkg::q_stat_t  q_stat
);
	import wgbd_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	cls_t            entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign q_stat.full  = (count_q == CntW'(QueueDepth));
	assign q_stat.empty = (count_q == '0);
	assign pop_cls      = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cls;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/wgbd_back.sv */
// back end: arming counters, burst machine and the result register
module wgbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wgbd_pkg::cfg_t    cfg,
	input  wgbd_pkg::q_stat_t q_stat,
	input  wgbd_pkg::cls_t    pop_cls,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output wgbd_pkg::res_t    res
);
	import wgbd_pkg::*;

	logic [1:0] phase_q;
	logic [7:0] timer_q;
	logic [3:0] hit_run_q;
	logic       armed_q;
	logic [9:0] worn_cnt_q;
	logic [9:0] unworn_cnt_q;
	logic       motor_q;
	logic       out_valid_q;
	res_t       out_q;

	logic [1:0] phase_d;
	logic [7:0] timer_d;
	logic [3:0] hit_run_d;
	logic       armed_d;
	logic [9:0] worn_cnt_d;
	logic [9:0] unworn_cnt_d;
	logic       motor_d;
	logic       arm_p;
	logic       disarm_p;
	logic [9:0] worn_inc;
	logic [9:0] unworn_inc;
	logic [3:0] hit_inc;
	logic [7:0] timer_dec;

	// take an item when the result register is free or drains this cycle
	assign pop      = !q_stat.empty && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign res      = out_q;

	// saturating increments and timer decrement
	assign worn_inc   = (worn_cnt_q == 10'h3FF) ? worn_cnt_q : worn_cnt_q + 10'd1;
	assign unworn_inc = (unworn_cnt_q == 10'h3FF) ? unworn_cnt_q : unworn_cnt_q + 10'd1;
	assign hit_inc    = (hit_run_q == 4'hF) ? hit_run_q : hit_run_q + 4'd1;
	assign timer_dec  = timer_q - 8'd1;

	// next state for one classified chunk
	always_comb begin
		phase_d      = phase_q;
		timer_d      = timer_q;
		hit_run_d    = hit_run_q;
		armed_d      = armed_q;
		worn_cnt_d   = worn_cnt_q;
		unworn_cnt_d = unworn_cnt_q;
		motor_d      = motor_q;
		arm_p        = 1'b0;
		disarm_p     = 1'b0;
		if (pop_cls.worn) begin
			if (!armed_q) begin
				worn_cnt_d = worn_inc;
				if (worn_inc >= cfg.arm_chunks) begin
					armed_d = 1'b1;
					arm_p   = 1'b1;
					motor_d = 1'b0;
				end
			end else begin
				// burst machine, unused code behaves as idle
				unique case (phase_q)
					PH_ACTIVE: begin
						timer_d = timer_dec;
						if (timer_dec == 8'd0) begin
							motor_d = 1'b0;
							phase_d = PH_REFR;
							timer_d = cfg.refractory_length;
						end
					end
					PH_REFR: begin
						timer_d = timer_dec;
						if (timer_dec == 8'd0) begin
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d   = PH_IDLE;
						hit_run_d = pop_cls.hit ? hit_inc : 4'd0;
						if ((pop_cls.hit ? hit_inc : 4'd0) >= cfg.hits_needed) begin
							motor_d   = 1'b1;
							phase_d   = PH_ACTIVE;
							timer_d   = cfg.burst_length;
							hit_run_d = 4'd0;
						end
					end
				endcase
			end
		end else begin
			worn_cnt_d = 10'd0;
			if (armed_q) begin
				unworn_cnt_d = unworn_inc;
				if (unworn_inc >= cfg.disarm_chunks) begin
					armed_d      = 1'b0;
					disarm_p     = 1'b1;
					motor_d      = 1'b0;
					unworn_cnt_d = 10'd0;
				end
			end
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			hit_run_q    <= '0;
			armed_q      <= 1'b0;
			worn_cnt_q   <= '0;
			unworn_cnt_q <= '0;
			motor_q      <= 1'b0;
		end else if (pop) begin
			phase_q      <= phase_d;
			timer_q      <= timer_d;
			hit_run_q    <= hit_run_d;
			armed_q      <= armed_d;
			worn_cnt_q   <= worn_cnt_d;
			unworn_cnt_q <= unworn_cnt_d;
			motor_q      <= motor_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.motor_drive  <= motor_d;
			out_q.armed        <= armed_d;
			out_q.arm_pulse    <= arm_p;
			out_q.disarm_pulse <= disarm_p;
			out_q.det_state    <= phase_d;
		end
	end

endmodule

/* rtl/core/wear_gated_burst_detector.sv */
// wear gated burst detector: each item passes the queue and the result register
// throughput one item per cycle while the result side keeps taking items
// the front classifies in the accept cycle, a two entry queue feeds the back end,
// whose single state update per cycle and result register set the rate
// arst_n clears all detector state and restores the configuration register defaults
module wear_gated_burst_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] energy
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] motor_drive, [1] armed, [2] arm_pulse,
	                               // [3] disarm_pulse, [5:4] det_state, [7:6] zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import wgbd_pkg::*;

	cfg_t    cfg_q;
	q_stat_t q_stat;
	cls_t    push_cls;
	cls_t    pop_cls;
	logic    push;
	logic    pop;
	res_t    res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_threshold     <= 32'd7000;
			cfg_q.worn_upper_bound  <= 32'd15000;
			cfg_q.burst_length      <= 8'd4;
			cfg_q.refractory_length <= 8'd24;
			cfg_q.hits_needed       <= 4'd2;
			cfg_q.arm_chunks        <= 10'd78;
			cfg_q.disarm_chunks     <= 10'd78;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIT_THRESHOLD:     cfg_q.hit_threshold     <= cfg_data;
				REG_WORN_UPPER_BOUND:  cfg_q.worn_upper_bound  <= cfg_data;
				REG_BURST_LENGTH:      cfg_q.burst_length      <= cfg_data[7:0];
				REG_REFRACTORY_LENGTH: cfg_q.refractory_length <= cfg_data[7:0];
				REG_HITS_NEEDED:       cfg_q.hits_needed       <= cfg_data[3:0];
				REG_ARM_CHUNKS:        cfg_q.arm_chunks        <= cfg_data[9:0];
				REG_DISARM_CHUNKS:     cfg_q.disarm_chunks     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	wgbd_front u_front (
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.energy   (s_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_cls (push_cls)
	);

	wgbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.pop      (pop),
		.pop_cls  (pop_cls),
		.q_stat   (q_stat)
	);

	wgbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.pop_cls  (pop_cls),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	// pack the result item
	assign m_tdata = {2'b00, res};

`ifndef SYNTHESIS
	// arm and disarm never share an item
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
		else $error("arm and disarm pulse together");

	// an arm pulse leaves the block armed with the motor off
	a_arm_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[1] && !m_tdata[0]))
		else $error("arm pulse with wrong armed or motor level");

	// a disarm pulse leaves the block disarmed with the motor off
	a_disarm_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3]) |-> (!m_tdata[1] && !m_tdata[0]))
		else $error("disarm pulse with wrong armed or motor level");

	// the queue never pushes while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue overflow");
`endif

endmodule

/* dv/wgbd_checker.sv */
// checker for the wear gated burst detector: predicts each result item and compares
`timescale 1ns / 1ps

module wgbd_checker
	import wgbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] energy
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [0] motor_drive, [1] armed, [2] arm_pulse,
	                               // [3] disarm_pulse, [5:4] det_state, [7:6] zero
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          pending,
	output int          mismatches
);

	localparam cfg_t CFG_DEFAULT = '{
		hit_threshold:     32'd7000,
		worn_upper_bound:  32'd15000,
		burst_length:      8'd4,
		refractory_length: 8'd24,
		hits_needed:       4'd2,
		arm_chunks:        10'd78,
		disarm_chunks:     10'd78
	};

	// shadow copy of the registers and of the detector state
	cfg_t       cfg;
	logic [1:0] phase;
	logic [7:0] phase_left;
	logic [3:0] hit_streak;
	logic       is_armed;
	logic [9:0] worn_run;
	logic [9:0] unworn_run;
	logic       motor;

	res_t expected_results[$];

	initial mismatches = 0;

	// advance the detector by one chunk and return the result it should report
	function automatic res_t advance_detector(input logic [31:0] energy);
		res_t r;
		logic arm_p;
		logic disarm_p;
		arm_p    = 1'b0;
		disarm_p = 1'b0;
		if (energy != 32'd0 && energy < cfg.worn_upper_bound) begin
			if (!is_armed) begin
				// worn chunk while disarmed counts toward arming
				if (worn_run != 10'h3ff)
					worn_run = worn_run + 10'd1;
				if (worn_run >= cfg.arm_chunks) begin
					is_armed = 1'b1;
					arm_p    = 1'b1;
					motor    = 1'b0;
				end
			end else begin
				// worn chunk while armed drives the burst machine
				case (phase)
					PH_ACTIVE: begin
						phase_left = phase_left - 8'd1;
						if (phase_left == 8'd0) begin
							motor      = 1'b0;
							phase      = PH_REFR;
							phase_left = cfg.refractory_length;
						end
					end
					PH_REFR: begin
						phase_left = phase_left - 8'd1;
						if (phase_left == 8'd0)
							phase = PH_IDLE;
					end
					default: begin
						// unused code behaves as idle
						phase = PH_IDLE;
						if (energy > cfg.hit_threshold) begin
							if (hit_streak != 4'hf)
								hit_streak = hit_streak + 4'd1;
						end else begin
							hit_streak = 4'd0;
						end
						if (hit_streak >= cfg.hits_needed) begin
							motor      = 1'b1;
							phase      = PH_ACTIVE;
							phase_left = cfg.burst_length;
							hit_streak = 4'd0;
						end
					end
				endcase
			end
		end else begin
			// out of range chunk
			worn_run = 10'd0;
			if (is_armed) begin
				if (unworn_run != 10'h3ff)
					unworn_run = unworn_run + 10'd1;
				if (unworn_run >= cfg.disarm_chunks) begin
					is_armed   = 1'b0;
					disarm_p   = 1'b1;
					motor      = 1'b0;
					unworn_run = 10'd0;
				end
			end
		end
		r.motor_drive  = motor;
		r.armed        = is_armed;
		r.arm_pulse    = arm_p;
		r.disarm_pulse = disarm_p;
		r.det_state    = phase;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// track register writes, predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			cfg        = CFG_DEFAULT;
			phase      = PH_IDLE;
			phase_left = 8'd0;
			hit_streak = 4'd0;
			is_armed   = 1'b0;
			worn_run   = 10'd0;
			unworn_run = 10'd0;
			motor      = 1'b0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HIT_THRESHOLD:     cfg.hit_threshold     = cfg_data;
					REG_WORN_UPPER_BOUND:  cfg.worn_upper_bound  = cfg_data;
					REG_BURST_LENGTH:      cfg.burst_length      = cfg_data[7:0];
					REG_REFRACTORY_LENGTH: cfg.refractory_length = cfg_data[7:0];
					REG_HITS_NEEDED:       cfg.hits_needed       = cfg_data[3:0];
					REG_ARM_CHUNKS:        cfg.arm_chunks        = cfg_data[9:0];
					REG_DISARM_CHUNKS:     cfg.disarm_chunks     = cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(advance_detector(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result item expected none actual %02h", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					got  = res_t'(m_tdata[5:0]);
					check_field("motor_drive", want.motor_drive, got.motor_drive);
					check_field("armed", want.armed, got.armed);
					check_field("arm_pulse", want.arm_pulse, got.arm_pulse);
					check_field("disarm_pulse", want.disarm_pulse, got.disarm_pulse);
					check_field("det_state", want.det_state, got.det_state);
					check_field("pad", 2'd0, m_tdata[7:6]);
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// testbench top for the wear gated burst detector: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import wgbd_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = 32'd0;   // [31:0] energy
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;             // [0] motor_drive, [1] armed, [2] arm_pulse,
	                                  // [3] disarm_pulse, [5:4] det_state, [7:6] zero
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data  = 32'd0;

	int   pending;
	int   mismatches;
	int   quiet_cycles = 0;
	int   stall_left   = 0;
	int   idle_pct     = 0;
	logic no_idle      = 1'b0;
	cfg_t settings;

	wear_gated_burst_detector i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wgbd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.mismatches (mismatches)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls in bursts
	always @(posedge clk) begin
		if (!arst_n || no_idle) begin
			m_tready <= !no_idle ? 1'b0 : 1'b1;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready   <= 1'b1;
		end else if ($urandom_range(0, 99) < 15) begin
			stall_left <= $urandom_range(1, 11);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic cfg_t settings_of(input logic [31:0] thr, input logic [31:0] upper,
			input logic [7:0] burst, input logic [7:0] refr, input logic [3:0] hits,
			input logic [9:0] arm, input logic [9:0] disarm);
		cfg_t c;
		c.hit_threshold     = thr;
		c.worn_upper_bound  = upper;
		c.burst_length      = burst;
		c.refractory_length = refr;
		c.hits_needed       = hits;
		c.arm_chunks        = arm;
		c.disarm_chunks     = disarm;
		return c;
	endfunction

	// random energy: mostly worn chunks, some hits, the rest zero, at or above the bound, or random
	function automatic logic [31:0] pick_energy(input int hit_pct);
		logic [31:0] upper_m1;
		logic [31:0] miss_top;
		logic        can_hit;
		logic        can_miss;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 75 && settings.worn_upper_bound >= 32'd2) begin
			upper_m1 = settings.worn_upper_bound - 32'd1;
			can_hit  = settings.hit_threshold < upper_m1;
			can_miss = settings.hit_threshold != 32'd0;
			if (can_hit && ($urandom_range(0, 99) < hit_pct || !can_miss))
				return $urandom_range(upper_m1, settings.hit_threshold + 32'd1);
			miss_top = can_hit ? settings.hit_threshold : upper_m1;
			return $urandom_range(miss_top, 1);
		end
		case (roll % 3)
			0:       return 32'd0;
			1:       return $urandom_range(32'hffff_ffff, settings.worn_upper_bound);
			default: return $urandom;
		endcase
	endfunction

	// one input item, with an optional gap before it
	task automatic send_chunk(input logic [31:0] energy);
		if (!no_idle && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= energy;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// hold off input until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// write the whole register set while the block is idle
	task automatic load_settings(input cfg_t c);
		drain();
		write_reg(REG_HIT_THRESHOLD, c.hit_threshold);
		write_reg(REG_WORN_UPPER_BOUND, c.worn_upper_bound);
		write_reg(REG_BURST_LENGTH, {24'h0, c.burst_length});
		write_reg(REG_REFRACTORY_LENGTH, {24'h0, c.refractory_length});
		write_reg(REG_HITS_NEEDED, {28'h0, c.hits_needed});
		write_reg(REG_ARM_CHUNKS, {22'h0, c.arm_chunks});
		write_reg(REG_DISARM_CHUNKS, {22'h0, c.disarm_chunks});
		// index past the register set must be ignored
		write_reg(REG_UNUSED, $urandom);
		cfg_we   <= 1'b0;
		settings  = c;
	endtask

	task automatic run_phase(input cfg_t c, input int n_items, input int hit_pct);
		load_settings(c);
		idle_pct = 20 * $urandom_range(0, 2);
		for (int i = 0; i < n_items; i++) begin
			// sender waits out the result side once per phase
			if (i == n_items / 2)
				drain();
			send_chunk(pick_energy(hit_pct));
		end
	endtask

	// stimulus and verdict
	initial begin
		settings = settings_of(32'd7000, 32'd15000, 8'd4, 8'd24, 4'd2, 10'd78, 10'd78);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 30;

		// reset defaults
		send_chunk(32'hffff_ffff);
		send_chunk(32'd0);
		send_chunk(32'd14999);

		// arm, one short burst, refractory, disarm; threshold equality is not a hit
		load_settings(settings_of(32'd7000, 32'd15000, 8'd1, 8'd1, 4'd1, 10'd2, 10'd2));
		send_chunk(32'd0);
		send_chunk(32'd1);
		send_chunk(32'd14999);
		send_chunk(32'd15000);
		send_chunk(32'd7000);
		send_chunk(32'd7001);
		send_chunk(32'd5);
		send_chunk(32'd5);
		send_chunk(32'hffff_ffff);

		// zero hits, arm and disarm counts
		load_settings(settings_of(32'd0, 32'hffff_ffff, 8'd2, 8'd1, 4'd0, 10'd0, 10'd0));
		send_chunk(32'd1);
		send_chunk(32'hffff_fffe);
		send_chunk(32'hffff_ffff);
		send_chunk(32'h8000_0000);
		send_chunk(32'd1);

		// upper bound of zero or one leaves nothing worn
		load_settings(settings_of(32'hffff_ffff, 32'd0, 8'd1, 8'd1, 4'd1, 10'd1, 10'd0));
		send_chunk(32'd1);
		send_chunk(32'hffff_ffff);
		load_settings(settings_of(32'hffff_ffff, 32'd1, 8'd1, 8'd1, 4'd1, 10'd1, 10'd1));
		send_chunk(32'd1);
		send_chunk(32'd0);

		// random phases over a spread of settings
		run_phase(settings_of(32'd7000, 32'd15000, 8'd4, 8'd24, 4'd2, 10'd5, 10'd6), 60, 50);
		run_phase(settings_of(32'h8000_0000, 32'hffff_ffff, 8'd255, 8'd255, 4'd15, 10'd1,
			10'd1023), 80, 90);
		run_phase(settings_of(32'd1000, 32'hffff_0000, 8'd0, 8'd0, 4'd1, 10'd1, 10'd40),
			60, 60);
		run_phase(settings_of(32'd0, 32'd2, 8'd2, 8'd3, 4'd3, 10'd3, 10'd3), 60, 100);
		run_phase(settings_of(32'hffff_ffff, 32'hffff_ffff, 8'd1, 8'd1, 4'd1, 10'd4, 10'd1),
			40, 50);
		run_phase(settings_of(32'd7000, 32'd15000, 8'd8, 8'd6, 4'd4, 10'd1023, 10'd1023),
			20, 50);
		// last part runs with no idling on either side
		no_idle <= 1'b1;
		run_phase(settings_of(32'd7000, 32'd15000, 8'd3, 8'd5, 4'd2, 10'd4, 10'd5), 100, 60);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/wgbd_pkg.sv
rtl/core/wgbd_front.sv
rtl/core/wgbd_queue.sv
rtl/core/wgbd_back.sv
rtl/core/wear_gated_burst_detector.sv
dv/wgbd_checker.sv
dv/tb_top.sv
